// ===== rtl/sucs_pkg.sv =====
// ----------------------------------------------------------------------------
// sucs_pkg
// Shared codes and types for the sorted unique code set.
// ----------------------------------------------------------------------------
package sucs_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LIST   = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_ABSENT  = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     lt_left;  // left neighbour holds a code below the key
    logic     lt_here;  // this cell holds a code below the key
    logic     occ;      // this cell lies inside the stored run
    logic     is_tail;  // this cell holds the last stored code
  } cell_ctrl_t;

endpackage

// ===== rtl/sorted_unique_code_set_top.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_code_set_top
// Ascending set of distinct fault codes held in a chain of compare cells.
// ----------------------------------------------------------------------------
// insert, remove and unused ops: the key is compared in the CMP state and the
// result word is loaded in UPD, after which the block returns to idle; a list of
// n codes loads its entries from the LIST state, one a cycle while the output is
// free, the chain rotating one place per entry. one word in flight at a time, and a
// result word still waiting delays the next update until it is taken
// reset clears the state, the stored count, the list index and m_tvalid; cell contents stay as they are
module sorted_unique_code_set_top
  import sucs_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int CODE_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // code[7:0]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], entry_valid[2], entry_code[10:3], entry_index[14:11],
  // count[19:15], zero fill[23:20]
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_LIST = 2'd3;

  logic [1:0]            state;
  logic [1:0]            func_q;
  logic [CODE_WIDTH-1:0] key_q;
  logic [CODE_WIDTH+7:0] key_wide;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [CNT_W-1:0]      k;
  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   lt_q;
  logic                  hit_q;
  logic                  full;
  logic                  out_free;
  logic                  load;
  cell_op_t              op;

  logic [CODE_WIDTH-1:0] vals [CAPACITY];
  cell_ctrl_t            ctrl [CAPACITY];

  logic [1:0]            o_status;
  logic                  o_valid;
  logic [7:0]            o_code;
  logic [3:0]            o_index;
  logic [4:0]            o_count;
  logic                  o_last;

  logic [1:0]            ld_status;
  logic                  ld_valid;
  logic [7:0]            ld_code;
  logic [3:0]            ld_index;
  logic                  ld_last;
  logic [CODE_WIDTH+7:0] head_wide;
  logic [CNT_W+3:0]      k_wide;
  logic [CNT_W+4:0]      cnt_wide;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (cnt == CNT_W'(CAPACITY));
  assign key_wide = {{CODE_WIDTH{1'b0}}, s_tdata};
  assign head_wide = {8'b0, vals[0]};
  assign k_wide   = {4'b0, k};
  assign cnt_wide = {5'b0, cnt_next};

  assign m_tdata = {4'b0, o_count, o_index, o_code, o_valid, o_status};
  assign m_tlast = o_last;

  // per-cell control, all cells share the op
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].op      = op;
      ctrl[i].lt_left = (i == 0) ? 1'b1 : lt_q[(i == 0) ? 0 : i - 1];
      ctrl[i].lt_here = lt_q[i];
      ctrl[i].occ     = (CNT_W'(i) < cnt);
      ctrl[i].is_tail = (cnt == CNT_W'(i + 1));
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [CODE_WIDTH-1:0] lv;
    logic [CODE_WIDTH-1:0] rv;
    if (g == 0) begin : g_first
      assign lv = vals[0];
    end else begin : g_mid
      assign lv = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rv = vals[g];
    end else begin : g_inner
      assign rv = vals[g+1];
    end
    sucs_cell #(
      .CODE_WIDTH(CODE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl[g]),
      .key      (key_q),
      .left_val (lv),
      .right_val(rv),
      .head_val (vals[0]),
      .val      (vals[g]),
      .lt       (lt_vec[g]),
      .eq       (eq_vec[g])
    );
  end

  // decide op, count and the word to load
  always_comb begin
    op        = CELL_HOLD;
    cnt_next  = cnt;
    load      = 1'b0;
    ld_status = STAT_DONE;
    ld_valid  = 1'b0;
    ld_code   = 8'b0;
    ld_index  = 4'b0;
    ld_last   = 1'b1;
    case (state)
      ST_UPD: begin
        if (out_free) begin
          case (func_q)
            FUNC_INSERT: begin
              load = 1'b1;
              if (hit_q) begin
                ld_status = STAT_PRESENT;
              end else if (full) begin
                ld_status = STAT_FULL;
              end else begin
                op       = CELL_INSERT;
                cnt_next = cnt + 1'b1;
              end
            end
            FUNC_REMOVE: begin
              load = 1'b1;
              if (hit_q) begin
                op       = CELL_REMOVE;
                cnt_next = cnt - 1'b1;
              end else begin
                ld_status = STAT_ABSENT;
              end
            end
            FUNC_LIST: begin
              load = (cnt == '0);
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          load     = 1'b1;
          op       = CELL_ROTATE;
          ld_valid = 1'b1;
          ld_code  = head_wide[7:0];
          ld_index = k_wide[3:0];
          ld_last  = (k + 1'b1 == cnt);
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            k <= '0;
            if (func_q == FUNC_LIST && cnt != '0) begin
              state <= ST_LIST;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_LIST: begin
          if (out_free) begin
            k <= k + 1'b1;
            if (ld_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_q <= s_tuser;
      key_q  <= key_wide[CODE_WIDTH-1:0];
    end
    if (state == ST_CMP) begin
      lt_q  <= lt_vec;
      hit_q <= |eq_vec;
    end
    if (load) begin
      o_status <= ld_status;
      o_valid  <= ld_valid;
      o_code   <= ld_code;
      o_index  <= ld_index;
      o_count  <= cnt_wide[4:0];
      o_last   <= ld_last;
    end
  end

endmodule

// ===== rtl/sucs_cell.sv =====
// ----------------------------------------------------------------------------
// sucs_cell
// One slot of the sorted chain: holds a code, compares it with the key and
// takes a new value from the key, a neighbour or the head of the chain.
// ----------------------------------------------------------------------------
module sucs_cell
  import sucs_pkg::*;
#(
  parameter int CODE_WIDTH = 8
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [CODE_WIDTH-1:0] key,
  input  logic [CODE_WIDTH-1:0] left_val,
  input  logic [CODE_WIDTH-1:0] right_val,
  input  logic [CODE_WIDTH-1:0] head_val,
  output logic [CODE_WIDTH-1:0] val,
  output logic                  lt,
  output logic                  eq
);

  assign lt = ctrl.occ && (val < key);
  assign eq = ctrl.occ && (val == key);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (!ctrl.lt_here) begin
          val <= ctrl.lt_left ? key : left_val;
        end
      end
      CELL_REMOVE: begin
        if (!ctrl.lt_here) begin
          val <= right_val;
        end
      end
      CELL_ROTATE: begin
        val <= ctrl.is_tail ? head_val : right_val;
      end
      default: begin
        val <= val;
      end
    endcase
  end

endmodule

// ===== tb/sv/code_set_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// code_set_checker
// Watches both stream channels of the sorted code set. Every accepted request
// word updates a private copy of the ascending set and queues the result
// words it should cause; every accepted result word is compared field by
// field against the oldest queued one.
// ----------------------------------------------------------------------------
module code_set_checker
  import sucs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // code[7:0]
  input  logic [1:0]  s_tuser,   // func[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], entry_valid[2], entry_code[10:3], entry_index[14:11],
  // count[19:15], zero fill[23:20]
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  output int          fails,
  output int          pending,
  output int          results_seen,
  output int          lists_seen,
  output int          full_refusals
);

  typedef struct packed {
    logic [1:0] status;
    logic       entry_valid;
    logic [7:0] entry_code;
    logic [3:0] entry_index;
    logic [4:0] count;
    logic       last;
  } set_reply_t;

  logic [7:0] held_codes [CAPACITY];
  int         held_n;
  set_reply_t due_replies [$];

  int fail_n;
  int seen_n;
  int list_n;
  int full_n;
  int due_n;

  assign fails         = fail_n;
  assign pending       = due_n;
  assign results_seen  = seen_n;
  assign lists_seen    = list_n;
  assign full_refusals = full_n;

  task automatic report_fault(input string msg);
    $display("%0t checker: %s", $realtime, msg);
    fail_n++;
  endtask

  task automatic queue_reply(input logic [1:0] st, input logic ev, input logic [7:0] c,
                             input logic [3:0] idx, input logic lst);
    set_reply_t r;
    r.status      = st;
    r.entry_valid = ev;
    r.entry_code  = c;
    r.entry_index = idx;
    r.count       = held_n[4:0];
    r.last        = lst;
    due_replies.push_back(r);
  endtask

  // apply one request word to the private set and queue what it should give
  task automatic apply_request(input logic [1:0] f, input logic [7:0] c);
    int         pos;
    int         i;
    logic [1:0] st;
    pos = 0;
    case (f)
      FUNC_INSERT: begin
        while (pos < held_n && held_codes[pos] < c) pos++;
        if (pos < held_n && held_codes[pos] == c) begin
          st = STAT_PRESENT;
        end else if (held_n >= CAPACITY) begin
          st = STAT_FULL;
          full_n++;
        end else begin
          for (i = held_n; i > pos; i--) held_codes[i] = held_codes[i-1];
          held_codes[pos] = c;
          held_n++;
          st = STAT_DONE;
        end
        queue_reply(st, 1'b0, 8'd0, 4'd0, 1'b1);
      end
      FUNC_REMOVE: begin
        while (pos < held_n && held_codes[pos] != c) pos++;
        if (pos >= held_n) begin
          st = STAT_ABSENT;
        end else begin
          for (i = pos + 1; i < held_n; i++) held_codes[i-1] = held_codes[i];
          held_n--;
          st = STAT_DONE;
        end
        queue_reply(st, 1'b0, 8'd0, 4'd0, 1'b1);
      end
      FUNC_LIST: begin
        list_n++;
        if (held_n == 0) begin
          queue_reply(STAT_DONE, 1'b0, 8'd0, 4'd0, 1'b1);
        end else begin
          for (i = 0; i < held_n; i++)
            queue_reply(STAT_DONE, 1'b1, held_codes[i], i[3:0], i == held_n - 1);
        end
      end
      default: begin
        // spare opcode leaves the set alone
        queue_reply(STAT_DONE, 1'b0, 8'd0, 4'd0, 1'b1);
      end
    endcase
  endtask

  task automatic check_reply(input logic [23:0] d, input logic lst);
    set_reply_t w;
    if (due_replies.size() == 0) begin
      report_fault($sformatf("result word 0x%06h with nothing outstanding", d));
    end else begin
      w = due_replies.pop_front();
      if (d[1:0] != w.status)
        report_fault($sformatf("status got %0d want %0d", d[1:0], w.status));
      if (d[2] != w.entry_valid)
        report_fault($sformatf("entry_valid got %0d want %0d", d[2], w.entry_valid));
      if (d[10:3] != w.entry_code)
        report_fault($sformatf("entry_code got 0x%02h want 0x%02h", d[10:3], w.entry_code));
      if (d[14:11] != w.entry_index)
        report_fault($sformatf("entry_index got %0d want %0d", d[14:11], w.entry_index));
      if (d[19:15] != w.count)
        report_fault($sformatf("count got %0d want %0d", d[19:15], w.count));
      if (d[23:20] != 4'd0)
        report_fault($sformatf("fill bits got 0x%01h", d[23:20]));
      if (lst != w.last)
        report_fault($sformatf("last got %0d want %0d", lst, w.last));
    end
    seen_n++;
  endtask

  initial begin
    fail_n = 0;
    seen_n = 0;
    list_n = 0;
    full_n = 0;
    held_n = 0;
    due_n  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      held_n = 0;
      due_replies.delete();
    end else begin
      // result side first so a word cannot meet its own prediction early
      if (m_tvalid && m_tready) check_reply(m_tdata, m_tlast);
      if (s_tvalid && s_tready) apply_request(s_tuser, s_tdata);
    end
    due_n = due_replies.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the sorted unique code set: a directed pass over the empty,
// full and duplicate cases, then insert-heavy and remove-heavy episodes on a
// small code pool with random idling on both channels. Checking lives in
// code_set_checker.
// ----------------------------------------------------------------------------
module testbench
  import sucs_pkg::*;
();

  // the one opcode the package leaves unnamed
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int         POOL_SIZE  = 24;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  int fails;
  int pending;
  int results_seen;
  int lists_seen;
  int full_refusals;

  logic       calm;
  int         words_sent;
  logic [7:0] code_pool [POOL_SIZE];

  sorted_unique_code_set_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  code_set_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fails         (fails),
    .pending       (pending),
    .results_seen  (results_seen),
    .lists_seen    (lists_seen),
    .full_refusals (full_refusals)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("sorted_unique_code_set_top test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  task automatic send_word(input logic [1:0] f, input logic [7:0] c);
    while (!calm && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [1:0] pick_func(input logic filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)        return FUNC_SPARE;
    else if (r < 20)  return FUNC_LIST;
    else if (r < 35)  return filling ? FUNC_REMOVE : FUNC_INSERT;
    else              return filling ? FUNC_INSERT : FUNC_REMOVE;
  endfunction

  function automatic logic [7:0] pick_code();
    // mostly pool codes so removes hit and inserts collide
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return code_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  initial begin
    int k;
    int ep;
    int n;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= 8'd0;
    s_tuser    <= FUNC_INSERT;
    calm        = 1'b0;
    words_sent  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty listing, spare op, extremes, duplicate, fill to full
    send_word(FUNC_LIST, 8'hA5);
    send_word(FUNC_SPARE, 8'h5A);
    send_word(FUNC_INSERT, 8'hFF);
    send_word(FUNC_INSERT, 8'h00);
    send_word(FUNC_INSERT, 8'hFF);
    // scrambled order so inserts land in the middle and shift the tail up
    for (k = 0; k < 14; k++) send_word(FUNC_INSERT, 8'(((k * 5) % 14 + 1) * 17));
    send_word(FUNC_INSERT, 8'h80);
    send_word(FUNC_INSERT, 8'h44);
    send_word(FUNC_LIST, 8'h00);
    send_word(FUNC_REMOVE, 8'h00);
    send_word(FUNC_REMOVE, 8'hFF);
    send_word(FUNC_REMOVE, 8'h00);

    for (k = 0; k < POOL_SIZE; k++)
      code_pool[k] = (k < 16) ? 8'(k * 17) : 8'($urandom_range(0, 255));

    // alternate drain and fill episodes, the third one without any idling
    for (ep = 0; ep < 4; ep++) begin
      calm = (ep == 2);
      for (n = 0; n < 24; n++) send_word(pick_func(ep[0]), pick_code());
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("sent %0d request words, checked %0d result words", words_sent, results_seen);
    $display("%0d listings and %0d refused inserts into a full set", lists_seen,
             full_refusals);
    if (fails == 0) begin
      $display("sorted_unique_code_set_top test passed");
    end else begin
      $display("sorted_unique_code_set_top test failed");
    end
    $finish;
  end

endmodule
